// File: src/hgpc_pkg.sv
package hgpc_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int POS_FRAC_BITS_DEF = 16;

   // Widths of the rotation datapath: the yaw vector and the velocity vector.
   localparam int CW = 38;
   localparam int VW = 44;
   localparam int GUARD = 8;

   // Shared multiplier operand and product widths.
   localparam int MW = 34;
   localparam int PW = 68;

   // Reciprocal of the CORDIC gain, Q0.30.
   localparam logic [29:0] INV_K = 30'd652032874;
   // 1.0 in Q10.28.
   localparam logic signed [CW-1:0] YAW_ONE = 38'sd268435456;

   localparam logic [2:0] CSR_GOAL_X = 3'd0;
   localparam logic [2:0] CSR_GOAL_Y = 3'd1;
   localparam logic [2:0] CSR_P_GAIN = 3'd2;
   localparam logic [2:0] CSR_TOLERANCE = 3'd3;
   localparam logic [2:0] CSR_SPEED_LIMIT = 3'd4;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_ERR,
      FSM_MUL,
      FSM_DRAIN,
      FSM_DECIDE,
      FSM_ROT,
      FSM_DONE
   } fsm_type;

   typedef enum logic [3:0] {
      OP_AXX,
      OP_AYY,
      OP_TOL,
      OP_GX,
      OP_GY,
      OP_WZ,
      OP_XY,
      OP_YY,
      OP_ZZ,
      OP_KX,
      OP_KY
   } op_type;

   typedef enum logic [1:0] {
      MS_DRIVING,
      MS_ARRIVED,
      MS_CANCELED,
      MS_INACTIVE
   } status_type;

   typedef struct packed {
      logic                 valid;
      logic signed [CW-1:0] c;
      logic signed [CW-1:0] s;
      logic signed [VW-1:0] vx;
      logic signed [VW-1:0] vy;
   } cordic_bus_type;

   // Drops the guard bits with rounding and saturates to 32 bits.
   function automatic logic signed [31:0] unguard(input logic signed [VW-1:0] v);
      logic signed [VW-1:0] r;
      logic signed [VW-1:0] t;
      r = v + VW'(128);
      t = r >>> GUARD;
      if (t > $signed(VW'(32'h7FFF_FFFF))) begin
         return 32'sh7FFF_FFFF;
      end else if (t < -$signed(VW'(33'h1_0000_0000 >> 1))) begin
         return 32'sh8000_0000;
      end else begin
         return t[31:0];
      end
   endfunction

endpackage

// File: src/hgpc_cordic_cell.sv
module hgpc_cordic_cell #(
   parameter int SHIFT = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  hgpc_pkg::cordic_bus_type din,
   output hgpc_pkg::cordic_bus_type dout
);

   hgpc_pkg::cordic_bus_type bus_in;
   hgpc_pkg::cordic_bus_type bus_ff;

   // One vectoring micro-rotation, applied to the velocity in the same direction.
   always_comb begin
      bus_in = din;
      if ($signed(din.s) >= 0) begin
         bus_in.c = din.c + ($signed(din.s) >>> SHIFT);
         bus_in.s = din.s - ($signed(din.c) >>> SHIFT);
         bus_in.vx = din.vx + ($signed(din.vy) >>> SHIFT);
         bus_in.vy = din.vy - ($signed(din.vx) >>> SHIFT);
      end else begin
         bus_in.c = din.c - ($signed(din.s) >>> SHIFT);
         bus_in.s = din.s + ($signed(din.c) >>> SHIFT);
         bus_in.vx = din.vx - ($signed(din.vy) >>> SHIFT);
         bus_in.vy = din.vy + ($signed(din.vx) >>> SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff.valid <= 1'b0;
      end else begin
         bus_ff.valid <= bus_in.valid;
      end
      bus_ff.c <= bus_in.c;
      bus_ff.s <= bus_in.s;
      bus_ff.vx <= bus_in.vx;
      bus_ff.vy <= bus_in.vy;
   end

   assign dout = bus_ff;

endmodule

// File: src/hgpc_cordic_chain.sv
module hgpc_cordic_chain #(
   parameter int CORDIC_STEPS = hgpc_pkg::CORDIC_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  hgpc_pkg::cordic_bus_type din,
   output hgpc_pkg::cordic_bus_type dout
);

   hgpc_pkg::cordic_bus_type link [CORDIC_STEPS+1];

   assign link[0] = din;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      hgpc_cordic_cell #(
         .SHIFT(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .din  (link[i]),
         .dout (link[i+1])
      );
   end

   assign dout = link[CORDIC_STEPS];

endmodule

// File: src/holonomic_goal_p_controller.sv
// A driving request runs through the world-frame error and eleven shared
// multiplier passes, then the rotation chain unless it has arrived or the yaw
// lies on the x axis; canceled or finished requests go straight to the output.
// One transaction is processed at a time; a new request is taken while the
// previous response waits. Synchronous active-high reset restores the register
// defaults and clears the finished flag.
module holonomic_goal_p_controller #(
   parameter int CORDIC_STEPS = hgpc_pkg::CORDIC_STEPS_DEF,
   parameter int POS_FRAC_BITS = hgpc_pkg::POS_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic               req_cancel_req,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_cmd_vx,
   output logic signed [31:0] rsp_cmd_vy,
   output logic [1:0]         rsp_move_status,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam logic [30:0] TOL_RESET =
      31'(((64'd1 << POS_FRAC_BITS) * 64'd10 + 64'd50) / 64'd100);
   localparam logic [30:0] SPEED_RESET =
      31'(((64'd1 << POS_FRAC_BITS) * 64'd40 + 64'd50) / 64'd100);

   localparam int MW = hgpc_pkg::MW;
   localparam int PW = hgpc_pkg::PW;
   localparam int CW = hgpc_pkg::CW;
   localparam int VW = hgpc_pkg::VW;

   hgpc_pkg::fsm_type    state_ff, state_in;
   hgpc_pkg::op_type     op_ff, opd_ff;
   hgpc_pkg::status_type res_st_ff;

   logic signed [31:0] goal_x_ff, goal_y_ff;
   logic [15:0]        p_gain_ff;
   logic [30:0]        tol_ff, speed_ff;
   logic               goal_done_ff;

   logic signed [31:0] px_ff, py_ff;
   logic signed [15:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic [32:0]        ax_ff, ay_ff;
   logic               sx_ff, sy_ff;

   logic signed [MW-1:0] op_a, op_b;
   logic signed [PW-1:0] prod_ff;
   logic                 pv_ff;

   logic [63:0]        sq_ff;
   logic [61:0]        tol2_ff;
   logic signed [31:0] vx_ff, vy_ff, kx_ff, ky_ff;
   logic signed [33:0] ssum_ff, csum_ff;

   logic signed [31:0] res_vx_ff, res_vy_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_vx_ff, rsp_vy_ff;
   logic [1:0]         rsp_st_ff;

   logic               chain_load, out_load, arrived, neg;
   logic signed [32:0] dx, dy;
   logic [49:0]        rnd;
   logic [41:0]        gmag;
   logic [30:0]        gclamp;
   logic               gsign;
   logic signed [31:0] gvel;
   logic signed [PW-1:0] ksum;
   logic signed [CW-1:0] c_raw, s_raw;
   logic signed [VW-1:0] gx_ext, gy_ext;
   hgpc_pkg::cordic_bus_type chain_in, chain_out;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         p_gain_ff <= 16'd205;
         tol_ff <= TOL_RESET;
         speed_ff <= SPEED_RESET;
      end else if (csr_we) begin
         case (csr_index)
            hgpc_pkg::CSR_GOAL_X: goal_x_ff <= csr_wdata;
            hgpc_pkg::CSR_GOAL_Y: goal_y_ff <= csr_wdata;
            hgpc_pkg::CSR_P_GAIN: p_gain_ff <= csr_wdata[15:0];
            hgpc_pkg::CSR_TOLERANCE: tol_ff <= csr_wdata[30:0];
            hgpc_pkg::CSR_SPEED_LIMIT: speed_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_done_ff <= 1'b0;
      end else if (csr_we && (csr_index == hgpc_pkg::CSR_GOAL_X ||
                              csr_index == hgpc_pkg::CSR_GOAL_Y)) begin
         goal_done_ff <= 1'b0;
      end else if (out_load && (res_st_ff == hgpc_pkg::MS_ARRIVED ||
                                res_st_ff == hgpc_pkg::MS_CANCELED)) begin
         goal_done_ff <= 1'b1;
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hgpc_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      chain_load = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         hgpc_pkg::FSM_IDLE: begin
            if (req_valid) begin
               state_in = (goal_done_ff || req_cancel_req) ? hgpc_pkg::FSM_DONE
                                                           : hgpc_pkg::FSM_ERR;
            end
         end
         hgpc_pkg::FSM_ERR: state_in = hgpc_pkg::FSM_MUL;
         hgpc_pkg::FSM_MUL: begin
            if (op_ff == hgpc_pkg::OP_KY) begin
               state_in = hgpc_pkg::FSM_DRAIN;
            end
         end
         hgpc_pkg::FSM_DRAIN: state_in = hgpc_pkg::FSM_DECIDE;
         hgpc_pkg::FSM_DECIDE: begin
            if (arrived || ssum_ff == '0) begin
               state_in = hgpc_pkg::FSM_DONE;
            end else begin
               state_in = hgpc_pkg::FSM_ROT;
               chain_load = 1'b1;
            end
         end
         hgpc_pkg::FSM_ROT: begin
            if (chain_out.valid) begin
               state_in = hgpc_pkg::FSM_DONE;
            end
         end
         hgpc_pkg::FSM_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = hgpc_pkg::FSM_IDLE;
            end
         end
         default: state_in = hgpc_pkg::FSM_IDLE;
      endcase
   end

   assign req_ready = (state_ff == hgpc_pkg::FSM_IDLE);

   // Input capture and world-frame error.
   always_comb begin
      dx = {goal_x_ff[31], goal_x_ff} - {px_ff[31], px_ff};
      dy = {goal_y_ff[31], goal_y_ff} - {py_ff[31], py_ff};
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         px_ff <= req_pos_x;
         py_ff <= req_pos_y;
         qw_ff <= req_quat_w;
         qx_ff <= req_quat_x;
         qy_ff <= req_quat_y;
         qz_ff <= req_quat_z;
      end
      if (state_ff == hgpc_pkg::FSM_ERR) begin
         ax_ff <= dx[32] ? 33'(-dx) : 33'(dx);
         ay_ff <= dy[32] ? 33'(-dy) : 33'(dy);
         sx_ff <= dx[32];
         sy_ff <= dy[32];
      end
   end

   // Shared multiplier: one product per cycle, written back the cycle after.
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (op_ff)
         hgpc_pkg::OP_AXX: begin op_a = {1'b0, ax_ff}; op_b = {1'b0, ax_ff}; end
         hgpc_pkg::OP_AYY: begin op_a = {1'b0, ay_ff}; op_b = {1'b0, ay_ff}; end
         hgpc_pkg::OP_TOL: begin op_a = {3'b0, tol_ff}; op_b = {3'b0, tol_ff}; end
         hgpc_pkg::OP_GX: begin op_a = {1'b0, ax_ff}; op_b = {18'b0, p_gain_ff}; end
         hgpc_pkg::OP_GY: begin op_a = {1'b0, ay_ff}; op_b = {18'b0, p_gain_ff}; end
         hgpc_pkg::OP_WZ: begin
            op_a = {{18{qw_ff[15]}}, qw_ff};
            op_b = {{18{qz_ff[15]}}, qz_ff};
         end
         hgpc_pkg::OP_XY: begin
            op_a = {{18{qx_ff[15]}}, qx_ff};
            op_b = {{18{qy_ff[15]}}, qy_ff};
         end
         hgpc_pkg::OP_YY: begin
            op_a = {{18{qy_ff[15]}}, qy_ff};
            op_b = {{18{qy_ff[15]}}, qy_ff};
         end
         hgpc_pkg::OP_ZZ: begin
            op_a = {{18{qz_ff[15]}}, qz_ff};
            op_b = {{18{qz_ff[15]}}, qz_ff};
         end
         hgpc_pkg::OP_KX: begin
            op_a = {{2{vx_ff[31]}}, vx_ff};
            op_b = {4'b0, hgpc_pkg::INV_K};
         end
         hgpc_pkg::OP_KY: begin
            op_a = {{2{vy_ff[31]}}, vy_ff};
            op_b = {4'b0, hgpc_pkg::INV_K};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= (state_ff == hgpc_pkg::FSM_MUL);
      end
      prod_ff <= op_a * op_b;
      opd_ff <= op_ff;
      if (state_ff == hgpc_pkg::FSM_ERR) begin
         op_ff <= hgpc_pkg::OP_AXX;
      end else if (state_ff == hgpc_pkg::FSM_MUL) begin
         op_ff <= hgpc_pkg::op_type'(op_ff + 4'd1);
      end
   end

   // Gain product: round, clamp to the speed limit, restore the sign.
   always_comb begin
      rnd = {1'b0, prod_ff[48:0]} + 50'd128;
      gmag = rnd[49:8];
      gclamp = (gmag > {11'b0, speed_ff}) ? speed_ff : gmag[30:0];
      gsign = (opd_ff == hgpc_pkg::OP_GX) ? sx_ff : sy_ff;
      gvel = gsign ? -$signed({1'b0, gclamp}) : $signed({1'b0, gclamp});
      ksum = prod_ff + (PW'(1) <<< 29);
   end

   always_ff @(posedge clock) begin
      if (pv_ff) begin
         case (opd_ff)
            hgpc_pkg::OP_AXX: sq_ff <= prod_ff[63:0];
            hgpc_pkg::OP_AYY: sq_ff <= sq_ff + prod_ff[63:0];
            hgpc_pkg::OP_TOL: tol2_ff <= prod_ff[61:0];
            hgpc_pkg::OP_GX: vx_ff <= gvel;
            hgpc_pkg::OP_GY: vy_ff <= gvel;
            hgpc_pkg::OP_WZ: ssum_ff <= prod_ff[33:0];
            hgpc_pkg::OP_XY: ssum_ff <= ssum_ff + prod_ff[33:0];
            hgpc_pkg::OP_YY: csum_ff <= prod_ff[33:0];
            hgpc_pkg::OP_ZZ: csum_ff <= csum_ff + prod_ff[33:0];
            hgpc_pkg::OP_KX: kx_ff <= ksum[61:30];
            hgpc_pkg::OP_KY: ky_ff <= ksum[61:30];
            default: ;
         endcase
      end
   end

   // Arrival test and loading of the rotation chain.
   always_comb begin
      arrived = (ax_ff < {2'b0, tol_ff}) && (ay_ff < {2'b0, tol_ff}) &&
                (sq_ff < {2'b0, tol2_ff});
      s_raw = {{(CW-35){ssum_ff[33]}}, ssum_ff, 1'b0};
      c_raw = hgpc_pkg::YAW_ONE - {{(CW-35){csum_ff[33]}}, csum_ff, 1'b0};
      neg = c_raw[CW-1];
      gx_ext = {{(VW-40){kx_ff[31]}}, kx_ff, 8'b0};
      gy_ext = {{(VW-40){ky_ff[31]}}, ky_ff, 8'b0};
      chain_in.valid = chain_load;
      chain_in.c = neg ? -c_raw : c_raw;
      chain_in.s = neg ? -s_raw : s_raw;
      chain_in.vx = neg ? -gx_ext : gx_ext;
      chain_in.vy = neg ? -gy_ext : gy_ext;
   end

   hgpc_cordic_chain #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_chain (
      .clock(clock),
      .reset(reset),
      .din  (chain_in),
      .dout (chain_out)
   );

   // Result staging and the output register.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         res_vx_ff <= '0;
         res_vy_ff <= '0;
         if (goal_done_ff) begin
            res_st_ff <= hgpc_pkg::MS_INACTIVE;
         end else if (req_cancel_req) begin
            res_st_ff <= hgpc_pkg::MS_CANCELED;
         end else begin
            res_st_ff <= hgpc_pkg::MS_DRIVING;
         end
      end else if (state_ff == hgpc_pkg::FSM_DECIDE) begin
         if (arrived) begin
            res_st_ff <= hgpc_pkg::MS_ARRIVED;
         end else if (ssum_ff == '0) begin
            // Yaw lies on the x axis: no rotation and no gain correction.
            res_vx_ff <= neg ? -vx_ff : vx_ff;
            res_vy_ff <= neg ? -vy_ff : vy_ff;
         end
      end else if (state_ff == hgpc_pkg::FSM_ROT && chain_out.valid) begin
         res_vx_ff <= hgpc_pkg::unguard(chain_out.vx);
         res_vy_ff <= hgpc_pkg::unguard(chain_out.vy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_vx_ff <= res_vx_ff;
         rsp_vy_ff <= res_vy_ff;
         rsp_st_ff <= res_st_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cmd_vx = rsp_vx_ff;
   assign rsp_cmd_vy = rsp_vy_ff;
   assign rsp_move_status = rsp_st_ff;

   a_chain_only_in_rot: assert property (@(posedge clock) disable iff (reset)
      chain_out.valid |-> state_ff == hgpc_pkg::FSM_ROT)
      else $error("rotation chain finished outside the rotate state");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff != hgpc_pkg::FSM_IDLE)
      else $error("accepted transaction did not start processing");

   a_zero_when_stopped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_move_status != hgpc_pkg::MS_DRIVING) |->
      (rsp_cmd_vx == '0 && rsp_cmd_vy == '0))
      else $error("nonzero command with a stopped status");

   a_load_drains_output: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

endmodule
